>>> hw/rtl/wclm_pkg.sv
// ----------------------------------------------------------------------------
// wclm_pkg
// Shared types and constants for the windowed cpu load monitor: field widths,
// window codes, register indexes, the command word and the back-end states.
// ----------------------------------------------------------------------------
package wclm_pkg;

  // core and window geometry
  localparam int NUM_CORES   = 2;
  localparam int CORE_W      = 1;
  localparam int NUM_WINDOWS = 3;
  localparam int WIN_W       = 2;

  // field widths
  localparam int TS_W   = 64;
  localparam int ACC_W  = 32;
  localparam int LOAD_W = 7;
  localparam int SECS_W = 32;

  // load arithmetic widths: running*100 and running+idle
  localparam int PROD_W     = ACC_W + LOAD_W;
  localparam int SUM_W      = ACC_W + 1;
  localparam int DIV_CNT_W  = $clog2(LOAD_W);

  localparam logic [LOAD_W-1:0] LOAD_RESET = LOAD_W'(100);
  localparam logic [LOAD_W-1:0] PCT_SCALE  = LOAD_W'(100);

  // query thresholds in seconds
  localparam logic [SECS_W-1:0] LONG_QUERY_SECONDS = SECS_W'(300);
  localparam logic [SECS_W-1:0] MID_QUERY_SECONDS  = SECS_W'(60);

  // window codes
  localparam logic [WIN_W-1:0] WIN_SHORT = WIN_W'(0);
  localparam logic [WIN_W-1:0] WIN_MID   = WIN_W'(1);
  localparam logic [WIN_W-1:0] WIN_LONG  = WIN_W'(2);

  // configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MID_WINDOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = CFG_IDX_W'(2);
  localparam logic [ACC_W-1:0] SHORT_WINDOW_RESET = ACC_W'(1000000);
  localparam logic [ACC_W-1:0] MID_WINDOW_RESET   = ACC_W'(60000000);
  localparam logic [ACC_W-1:0] LONG_WINDOW_RESET  = ACC_W'(300000000);

  // stream word widths
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 8;

  // command queue geometry
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [1:0] {
    CMD_SWITCH,
    CMD_QUERY,
    CMD_QUERY_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CORE_W-1:0] core;
    logic [TS_W-1:0]   ts;
    logic              idle;
    logic [WIN_W-1:0]  win;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } back_state_e;

endpackage

>>> hw/rtl/wclm_front.sv
// ----------------------------------------------------------------------------
// wclm_front
// Input side: unpacks the incoming word, sorts it into a switch event or a
// query, picks the query window and pushes a command into the queue.
// ----------------------------------------------------------------------------
module wclm_front (
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [wclm_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  output logic                             push_o,
  output wclm_pkg::cmd_t                   cmd_o,
  input  logic                             full_i
);
  import wclm_pkg::*;

  logic [CORE_W-1:0] core;
  logic [TS_W-1:0]   ts;
  logic              idle;
  logic [SECS_W-1:0] secs;
  logic              core_ok;
  logic              is_query;
  logic              keep;

  // unpack the word
  assign core     = s_axis_tdata_i[CORE_W-1:0];
  assign ts       = s_axis_tdata_i[CORE_W+TS_W-1:CORE_W];
  assign idle     = s_axis_tdata_i[CORE_W+TS_W];
  assign secs     = s_axis_tdata_i[CORE_W+TS_W+SECS_W:CORE_W+TS_W+1];
  assign is_query = s_axis_tuser_i;
  assign core_ok  = 32'(core) < 32'(NUM_CORES);

  // switch events on a missing core are dropped here
  assign keep            = is_query || core_ok;
  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i && keep;

  // build the command
  always_comb begin
    cmd_o      = '0;
    cmd_o.core = core;
    cmd_o.ts   = ts;
    cmd_o.idle = idle;
    if (!is_query) begin
      cmd_o.kind = CMD_SWITCH;
    end else if (core_ok) begin
      cmd_o.kind = CMD_QUERY;
    end else begin
      cmd_o.kind = CMD_QUERY_ZERO;
    end
    if (secs >= LONG_QUERY_SECONDS) begin
      cmd_o.win = WIN_LONG;
    end else if (secs >= MID_QUERY_SECONDS) begin
      cmd_o.win = WIN_MID;
    end else begin
      cmd_o.win = WIN_SHORT;
    end
  end

endmodule

>>> hw/rtl/wclm_queue.sv
// ----------------------------------------------------------------------------
// wclm_queue
// Short command queue between the front and the back end, so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module wclm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wclm_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output wclm_pkg::cmd_t  cmd_o,
  output logic            empty_o,
  output logic            full_o
);
  import wclm_pkg::*;

  cmd_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");
`endif

endmodule

>>> hw/rtl/wclm_back.sv
// ----------------------------------------------------------------------------
// wclm_back
// Back end: holds the per-core window state, charges switch events window by
// window through one shared multiply and a bit-serial divider, answers
// queries into the output register.
// ----------------------------------------------------------------------------
module wclm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [wclm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wclm_pkg::ACC_W-1:0]      cfg_data_i,
  input  wclm_pkg::cmd_t                  cmd_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [wclm_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);
  import wclm_pkg::*;

  back_state_e state_q, state_d;

  // window lengths
  logic [ACC_W-1:0] short_len_q, mid_len_q, long_len_q;

  // per-core and per-window state
  logic [TS_W-1:0]   last_q    [NUM_CORES];
  logic              prev_idle_q [NUM_CORES];
  logic [ACC_W-1:0]  idle_q    [NUM_CORES][NUM_WINDOWS];
  logic [ACC_W-1:0]  run_q     [NUM_CORES][NUM_WINDOWS];
  logic [ACC_W-1:0]  tot_q     [NUM_CORES][NUM_WINDOWS];
  logic [LOAD_W-1:0] load_q    [NUM_CORES][NUM_WINDOWS];

  // working registers
  logic [CORE_W-1:0]    core_q;
  logic [WIN_W-1:0]     w_q;
  logic [ACC_W-1:0]     elapsed_q;
  logic                 chg_idle_q;
  logic [PROD_W-1:0]    rem_q;
  logic [PROD_W-1:0]    den_sh_q;
  logic [LOAD_W-1:0]    quot_q;
  logic [DIV_CNT_W-1:0] bit_q;
  logic                 sum_zero_q;

  // output register
  logic              out_valid_q;
  logic [LOAD_W-1:0] out_load_q;

  logic              out_free;
  logic              take_switch;
  logic              take_query;
  logic [ACC_W-1:0]  diff;
  logic [ACC_W-1:0]  len;
  logic [ACC_W-1:0]  run_new, idle_new, tot_new;
  logic              latch;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic              ge;
  logic              last_win;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign last_win = (w_q == WIN_LONG);

  // elapsed time of the head event, zero counts as one
  assign diff = cmd_i.ts[ACC_W-1:0] - last_q[cmd_i.core][ACC_W-1:0];

  // window length select
  always_comb begin
    case (w_q)
      WIN_SHORT: len = short_len_q;
      WIN_MID:   len = mid_len_q;
      default:   len = long_len_q;
    endcase
  end

  // charge the current window
  assign run_new  = run_q[core_q][w_q] + (chg_idle_q ? '0 : elapsed_q);
  assign idle_new = idle_q[core_q][w_q] + (chg_idle_q ? elapsed_q : '0);
  assign tot_new  = tot_q[core_q][w_q] + elapsed_q;
  assign latch    = (tot_new >= len);

  // load numerator and denominator
  assign sum  = SUM_W'(run_q[core_q][w_q]) + SUM_W'(idle_q[core_q][w_q]);
  assign prod = PROD_W'(run_q[core_q][w_q]) * PROD_W'(PCT_SCALE);
  assign ge   = (rem_q >= den_sh_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_switch) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (latch) begin
          state_d = ST_MUL;
        end else if (last_win) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (bit_q == '0) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (last_win) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take_switch = 1'b0;
    take_query  = 1'b0;
    if (state_q == ST_IDLE && !empty_i) begin
      if (cmd_i.kind == CMD_SWITCH) begin
        take_switch = 1'b1;
      end else begin
        take_query = out_free;
      end
    end
    pop_o = take_switch || take_query;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= SHORT_WINDOW_RESET;
      mid_len_q   <= MID_WINDOW_RESET;
      long_len_q  <= LONG_WINDOW_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SHORT_WINDOW: short_len_q <= cfg_data_i;
        REG_MID_WINDOW:   mid_len_q   <= cfg_data_i;
        REG_LONG_WINDOW:  long_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-core window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        last_q[c]      <= '0;
        prev_idle_q[c] <= 1'b0;
        for (int w = 0; w < NUM_WINDOWS; w++) begin
          idle_q[c][w] <= '0;
          run_q[c][w]  <= '0;
          tot_q[c][w]  <= '0;
          load_q[c][w] <= LOAD_RESET;
        end
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take_switch) begin
            last_q[cmd_i.core]      <= cmd_i.ts;
            prev_idle_q[cmd_i.core] <= cmd_i.idle;
          end
        end
        ST_ACC: begin
          idle_q[core_q][w_q] <= idle_new;
          run_q[core_q][w_q]  <= run_new;
          tot_q[core_q][w_q]  <= tot_new;
        end
        ST_WRITE: begin
          if (!sum_zero_q) begin
            load_q[core_q][w_q] <= quot_q;
          end
          idle_q[core_q][w_q] <= '0;
          run_q[core_q][w_q]  <= '0;
          tot_q[core_q][w_q]  <= '0;
        end
        default: ;
      endcase
    end
  end

  // window walk and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WIN_SHORT;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take_switch) begin
            w_q <= WIN_SHORT;
          end
        end
        ST_ACC: begin
          if (!latch && !last_win) begin
            w_q <= w_q + 1'b1;
          end
        end
        ST_WRITE: begin
          if (!last_win) begin
            w_q <= w_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take_switch) begin
          core_q     <= cmd_i.core;
          elapsed_q  <= (diff == '0) ? ACC_W'(1) : diff;
          chg_idle_q <= prev_idle_q[cmd_i.core];
        end
      end
      ST_MUL: begin
        rem_q      <= prod;
        den_sh_q   <= {sum, (LOAD_W-1)'(0)};
        sum_zero_q <= (sum == '0);
        quot_q     <= '0;
        bit_q      <= DIV_CNT_W'(LOAD_W-1);
      end
      ST_DIV: begin
        if (ge) begin
          rem_q <= rem_q - den_sh_q;
        end
        den_sh_q <= den_sh_q >> 1;
        quot_q   <= {quot_q[LOAD_W-2:0], ge};
        bit_q    <= bit_q - 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_query) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_query) begin
      out_load_q <= (cmd_i.kind == CMD_QUERY) ? load_q[cmd_i.core][cmd_i.win] : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'(out_load_q);

`ifndef SYNTHESIS
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && !sum_zero_q) |-> (quot_q <= PCT_SCALE))
    else $error("latched load above 100 percent");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sum_zero_q) |-> ({1'b0, rem_q} < {den_sh_q, 1'b0}))
    else $error("divider remainder out of range");

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (w_q <= WIN_LONG))
    else $error("window index beyond the long window");
`endif

endmodule

>>> hw/rtl/windowed_cpu_load_monitor_unit.sv
// ----------------------------------------------------------------------------
// windowed_cpu_load_monitor_unit
// Per-core cpu load monitor over a short, a one-minute and a five-minute
// window, fed by task switch events and answering load queries.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per switch event or query; tuser high marks a
//   query. A switch event gives no result, a query gives one word on m_axis
//   with the latched load of the chosen window of that core (0 for a core
//   that does not exist).
//   cfg writes set the three window lengths in microseconds (index 0 short,
//   1 mid, 2 long); cfg_ready_o is always high; writes must go in while idle (not enforced).
// Operation:
//   a query's word is valid on m_axis in the cycle after the back end takes it
//   from the queue, which it does when idle and the output register is free.
//   A switch event occupies the back end: it is taken, each window is charged in
//   turn, and each window that closes passes the multiply, the bit-serial divider (seven steps) and the write.
//   A two-entry queue lets the input run ahead of the back end.
// Reset: windows cleared, all loads read 100, lengths at their defaults.
// Stall: a waiting result holds in the output register; the back end keeps
//   charging switch events but holds the next query until the word is taken.
// ----------------------------------------------------------------------------
module windowed_cpu_load_monitor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wclm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wclm_pkg::ACC_W-1:0]      cfg_data_i,
  // input words
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // core_index[0], timestamp_us[64:1], incoming_is_idle[65],
  // query_seconds[97:66], zero fill[103:98]
  input  logic [wclm_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode[0]
  input  logic                            s_axis_tuser_i,
  // result words
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // load_percent[6:0], zero fill[7]
  output logic [wclm_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);
  import wclm_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic empty;
  logic full;

  assign cfg_ready_o = 1'b1;

  // input side
  wclm_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  // command queue
  wclm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  // execution side
  wclm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (head_cmd),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the windowed cpu load monitor. Task switch events
// and load queries go in on the input stream. A scoreboard keeps its own
// copy of the per-core windows and predicts the load word for each query.
// The run covers the reset window lengths, the shortest and longest
// windows, wrapping counters, timestamps that step back, and a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import wclm_pkg::*;

  // stream opcodes carried on tuser
  localparam logic OP_SWITCH = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam int MAX_WAIT    = 17;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 150;
  localparam int RUN_LIMIT   = 2000000;

  // scoreboard: window model per core and the queue of load words due
  class load_scoreboard;
    logic [ACC_W-1:0]  window_len [NUM_WINDOWS];
    logic [TS_W-1:0]   last_ts    [NUM_CORES];
    logic              prev_idle  [NUM_CORES];
    logic [ACC_W-1:0]  idle_us    [NUM_CORES][NUM_WINDOWS];
    logic [ACC_W-1:0]  busy_us    [NUM_CORES][NUM_WINDOWS];
    logic [ACC_W-1:0]  total_us   [NUM_CORES][NUM_WINDOWS];
    logic [LOAD_W-1:0] load_pct   [NUM_CORES][NUM_WINDOWS];
    logic [LOAD_W-1:0] loads_due  [$];
    int errors;

    function new();
      window_len[WIN_SHORT] = SHORT_WINDOW_RESET;
      window_len[WIN_MID]   = MID_WINDOW_RESET;
      window_len[WIN_LONG]  = LONG_WINDOW_RESET;
      for (int c = 0; c < NUM_CORES; c++) begin
        last_ts[c]   = '0;
        prev_idle[c] = 1'b0;
        for (int w = 0; w < NUM_WINDOWS; w++) begin
          idle_us[c][w]  = '0;
          busy_us[c][w]  = '0;
          total_us[c][w] = '0;
          load_pct[c][w] = LOAD_RESET;
        end
      end
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("error at %0t: %s", $realtime, msg);
    endtask

    function void set_window(logic [CFG_IDX_W-1:0] idx, logic [ACC_W-1:0] len);
      case (idx)
        REG_SHORT_WINDOW: window_len[WIN_SHORT] = len;
        REG_MID_WINDOW:   window_len[WIN_MID]   = len;
        REG_LONG_WINDOW:  window_len[WIN_LONG]  = len;
        default: ;
      endcase
    endfunction

    // charge the time since the last switch, then close full windows
    function void charge_switch(int core, logic [TS_W-1:0] ts, logic idle_in);
      logic [ACC_W-1:0]  elapsed;
      logic [PROD_W-1:0] scaled;
      logic [SUM_W-1:0]  span;
      elapsed = ACC_W'(ts - last_ts[core]);
      if (elapsed == '0) elapsed = ACC_W'(1);
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        if (prev_idle[core]) idle_us[core][w] += elapsed;
        else busy_us[core][w] += elapsed;
        total_us[core][w] += elapsed;
      end
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        if (total_us[core][w] >= window_len[w]) begin
          scaled = PROD_W'(busy_us[core][w]) * PROD_W'(PCT_SCALE);
          span   = SUM_W'(busy_us[core][w]) + SUM_W'(idle_us[core][w]);
          // an empty window keeps its old load
          if (span != '0) load_pct[core][w] = LOAD_W'(scaled / span);
          idle_us[core][w]  = '0;
          busy_us[core][w]  = '0;
          total_us[core][w] = '0;
        end
      end
      last_ts[core]   = ts;
      prev_idle[core] = idle_in;
    endfunction

    // note an accepted input word
    function void note_input(logic op, logic [S_TDATA_W-1:0] word);
      int               core;
      logic [SECS_W-1:0] secs;
      core = int'(word[0]);
      secs = word[97:66];
      if (op == OP_SWITCH) begin
        if (core < NUM_CORES) charge_switch(core, word[64:1], word[65]);
      end else if (core >= NUM_CORES) begin
        loads_due.push_back('0);
      end else if (secs >= LONG_QUERY_SECONDS) begin
        loads_due.push_back(load_pct[core][WIN_LONG]);
      end else if (secs >= MID_QUERY_SECONDS) begin
        loads_due.push_back(load_pct[core][WIN_MID]);
      end else begin
        loads_due.push_back(load_pct[core][WIN_SHORT]);
      end
    endfunction

    // compare an accepted result word with the oldest load due
    task check_result(logic [M_TDATA_W-1:0] word);
      logic [LOAD_W-1:0] due;
      if (loads_due.size() == 0) begin
        report($sformatf("result word %0d with no query waiting", word[LOAD_W-1:0]));
      end else begin
        due = loads_due.pop_front();
        if (word[LOAD_W-1:0] !== due)
          report($sformatf("load_percent %0d, predicted %0d", word[LOAD_W-1:0], due));
      end
    endtask

    function int pending();
      return loads_due.size();
    endfunction

    task flush_leftovers();
      if (loads_due.size() != 0)
        report($sformatf("%0d query results never arrived", loads_due.size()));
    endtask
  endclass

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = REG_SHORT_WINDOW;
  logic [ACC_W-1:0]       cfg_data_i      = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = OP_SWITCH;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;

  load_scoreboard sb = new();

  // per-core time base for generated switch events
  logic [TS_W-1:0] core_now [NUM_CORES];
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit hold_off_req  = 1'b0;

  windowed_cpu_load_monitor_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // input and output monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_input(s_axis_tuser_i, s_axis_tdata_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o);
  end

  // result receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // one word on the input stream; called and returns at a falling edge
  task automatic send_word(logic op, logic core, logic [TS_W-1:0] ts, logic idle_in,
                           logic [SECS_W-1:0] secs);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'b0, secs, idle_in, ts, core};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // register write; leaves valid high for a following write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ACC_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_window(idx, len);
    @(negedge clk_i);
  endtask

  task automatic program_windows(logic [ACC_W-1:0] short_len, logic [ACC_W-1:0] mid_len,
                                 logic [ACC_W-1:0] long_len);
    cfg_write(REG_SHORT_WINDOW, short_len);
    cfg_write(REG_MID_WINDOW, mid_len);
    cfg_write(REG_LONG_WINDOW, long_len);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every query result, then for the back end to finish switches
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_LIMIT) @(negedge clk_i);
  endtask

  function automatic logic [SECS_W-1:0] pick_seconds();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 59);
      1:       return $urandom_range(60, 299);
      2:       return $urandom_range(300, 5000);
      default: return $urandom;
    endcase
  endfunction

  // random mix of switches and queries; a step limit of zero means full 32 bits
  task automatic run_random(int n_words, int unsigned step_limit, int query_pct);
    logic            op;
    logic            core;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] step;
    int              roll;
    for (int i = 0; i < n_words; i++) begin
      op   = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_SWITCH;
      core = 1'($urandom_range(0, 1));
      ts   = {$urandom, $urandom};
      if (op == OP_SWITCH) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) step = '0;
        else if (roll < 8) step = {$urandom, $urandom};   // may step backwards
        else if (step_limit == 0) step = TS_W'($urandom);
        else step = TS_W'($urandom_range(1, step_limit));
        core_now[core] += step;
        ts = core_now[core];
      end
      send_word(op, core, ts, 1'($urandom_range(0, 1)), pick_seconds());
    end
  endtask

  // main sequence
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset loads read 100 through every threshold
    send_word(OP_QUERY, 1'b0, '0, 1'b0, 32'd0);
    send_word(OP_QUERY, 1'b0, '1, 1'b1, 32'd59);
    send_word(OP_QUERY, 1'b0, '0, 1'b0, 32'd60);
    send_word(OP_QUERY, 1'b0, '1, 1'b1, 32'd299);
    send_word(OP_QUERY, 1'b0, '0, 1'b0, 32'd300);
    send_word(OP_QUERY, 1'b0, '1, 1'b1, 32'hFFFF_FFFF);
    // zero elapsed counts one, then close the short and mid windows
    send_word(OP_SWITCH, 1'b0, 64'd0, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_SWITCH, 1'b0, 64'd1_000_000, 1'b0, 32'd0);
    send_word(OP_SWITCH, 1'b0, 64'd61_000_000, 1'b1, 32'd0);
    send_word(OP_QUERY, 1'b0, '0, 1'b0, 32'd0);
    send_word(OP_QUERY, 1'b0, '0, 1'b0, 32'd60);
    send_word(OP_QUERY, 1'b0, '0, 1'b0, 32'd300);
    // largest elapsed, a timestamp going backwards, zero low word
    send_word(OP_SWITCH, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0);
    send_word(OP_SWITCH, 1'b1, 64'd5, 1'b1, 32'd0);
    send_word(OP_SWITCH, 1'b1, 64'd5, 1'b1, 32'd0);
    send_word(OP_SWITCH, 1'b1, 64'h8000_0000_0000_0005, 1'b1, 32'd0);
    send_word(OP_SWITCH, 1'b1, 64'h8000_0000_5000_0000, 1'b0, 32'd0);
    send_word(OP_QUERY, 1'b1, '0, 1'b0, 32'd0);
    send_word(OP_QUERY, 1'b1, '0, 1'b0, 32'd100);
    send_word(OP_QUERY, 1'b1, '0, 1'b0, 32'd400);
    settle();
    core_now[0] = 64'd61_000_000;
    core_now[1] = 64'h8000_0000_5000_0000;

    // shortest window, query heavy, with the receiver held off
    program_windows(32'd1, 32'd50, 32'd400);
    hold_off_req = 1'b1;
    run_random(100, 200, 80);
    settle();

    // random moderate windows
    program_windows($urandom_range(20, 500), $urandom_range(20, 500), $urandom_range(20, 500));
    run_random(100, 300, 35);
    settle();

    // longest windows with full-range steps so the counters wrap
    program_windows(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(80, 0, 35);
    settle();

    // mixed windows
    program_windows($urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(1, 2000));
    run_random(120, 600, 35);
    settle();

    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
